// ----- rtl/htd_pkg.sv -----
// shared types and constants of the huffman tree-walk decoder
package htd_pkg;

  localparam int IDX_W     = 9;
  localparam int SYM_W     = 8;
  localparam int IN_DATA_W = 48;

  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_DECODE = 1'b1;
  localparam logic [2:0] BIT_FIRST   = 3'd7;

  // one tree node as stored in the table
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]       pad;
    logic [SYM_W-1:0] data_byte;
    logic [IDX_W-1:0] node_right;
    logic [IDX_W-1:0] node_left;
    logic [SYM_W-1:0] node_symbol;
    logic             node_is_leaf;
    logic [IDX_W-1:0] node_index;
  } in_data_t;

endpackage

// ----- rtl/htd_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module htd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/huffman_tree_decoder_core.sv -----
// huffman tree-walk decoder: node table load and byte decode sequencer
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser: func, tdata: node fields and data byte
//  out_    | out | out_tvalid/out_tready| tdata: symbol, tlast: last
//  cfg_    | in  | cfg_we               | cfg_wdata: root_index
//
// a load request writes the node table on acceptance and leaves the block ready. a decode
// request is accepted, then per bit the cursor node is read (S_RDCUR, skipped if cached); a
// leaf cursor emits its symbol (S_CUR), else S_CUR reads the child, which S_NXT emits or caches;
// then S_FLUSH. the one read port of the node table sets the pace, one dependent read per tree step.
// reset is synchronous; the node table is not cleared.
// a full output register with a symbol waiting stalls the walk until out_tready.
module huffman_tree_decoder_core #(
  parameter int NODE_COUNT = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [8:0] node_index, [9] node_is_leaf, [17:10] node_symbol, [26:18] node_left,
  // [35:27] node_right, [43:36] data_byte, [47:44] zero
  input  logic [htd_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] symbol
  output logic [htd_pkg::SYM_W-1:0]        out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [htd_pkg::IDX_W-1:0]        cfg_wdata
);
  import htd_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RDCUR = 5'b00010,
    S_CUR   = 5'b00100,
    S_NXT   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  node_t            cur_node_r, cur_node_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0] next_r, next_nxt;
  logic [SYM_W-1:0] byte_r, byte_nxt;
  logic [2:0]       bit_cnt_r, bit_cnt_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0] pend_sym_r, pend_sym_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic             out_last_r, out_last_nxt;

  in_data_t         req;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [NODE_W-1:0] ram_rdata;
  node_t            ram_node, cnode;
  logic             rd_oor;
  logic [IDX_W-1:0] dir_idx;
  logic             out_free, emit_blocked, emit, bit_done;
  logic [SYM_W-1:0] emit_sym;

  function automatic logic idx_oor(input logic [IDX_W-1:0] idx);
    return 32'(idx) >= NODE_COUNT;
  endfunction

  assign req       = in_data_t'(in_tdata);
  assign ram_waddr = AW'(req.node_index);

  htd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({req.node_is_leaf, req.node_symbol, req.node_left, req.node_right}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entries beyond the table read as an inner node with both children zero
  assign rd_oor   = (state_r == S_NXT) ? idx_oor(next_r) : idx_oor(cursor_r);
  assign ram_node = rd_oor ? '0 : node_t'(ram_rdata);
  assign cnode    = cur_valid_r ? cur_node_r : ram_node;
  assign dir_idx  = byte_r[SYM_W-1] ? cnode.right : cnode.left;

  assign out_free     = !out_valid_r || out_tready;
  assign emit_blocked = pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    root_nxt       = root_r;
    cursor_nxt     = cursor_r;
    cur_node_nxt   = cur_node_r;
    cur_valid_nxt  = cur_valid_r;
    next_nxt       = next_r;
    byte_nxt       = byte_r;
    bit_cnt_nxt    = bit_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sym_nxt    = out_sym_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = AW'(cursor_r);
    emit           = 1'b0;
    emit_sym       = cnode.sym;
    bit_done       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == FUNC_LOAD) begin
            ram_we        = !idx_oor(req.node_index);
            cur_valid_nxt = 1'b0;
          end else begin
            byte_nxt    = req.data_byte;
            bit_cnt_nxt = BIT_FIRST;
            state_nxt   = cur_valid_r ? S_CUR : S_RDCUR;
          end
        end
      end
      S_RDCUR: begin
        ram_re    = 1'b1;
        state_nxt = S_CUR;
      end
      S_CUR: begin
        if (cnode.leaf) begin
          if (!emit_blocked) begin
            emit          = 1'b1;
            cursor_nxt    = root_r;
            cur_valid_nxt = 1'b0;
            bit_done      = 1'b1;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(dir_idx);
          next_nxt  = dir_idx;
          state_nxt = S_NXT;
        end
      end
      S_NXT: begin
        if (ram_node.leaf) begin
          if (!emit_blocked) begin
            emit          = 1'b1;
            emit_sym      = ram_node.sym;
            cursor_nxt    = root_r;
            cur_valid_nxt = 1'b0;
            bit_done      = 1'b1;
          end
        end else begin
          cursor_nxt    = next_r;
          cur_node_nxt  = ram_node;
          cur_valid_nxt = 1'b1;
          bit_done      = 1'b1;
        end
      end
      S_FLUSH: begin
        // the held symbol is the last of the byte
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sym_nxt    = pend_sym_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new symbol pushes the held one out, not marked last
    if (emit) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = pend_sym_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_sym_nxt   = emit_sym;
    end

    if (bit_done) begin
      byte_nxt = {byte_r[SYM_W-2:0], 1'b0};
      if (bit_cnt_r == 3'd0) begin
        state_nxt = S_FLUSH;
      end else begin
        bit_cnt_nxt = bit_cnt_r - 3'd1;
        state_nxt   = cur_valid_nxt ? S_CUR : S_RDCUR;
      end
    end

    if (cfg_we) begin
      root_nxt      = cfg_wdata;
      cursor_nxt    = cfg_wdata;
      cur_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      root_r       <= '0;
      cursor_r     <= '0;
      cur_valid_r  <= 1'b0;
      bit_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_r       <= root_nxt;
      cursor_r     <= cursor_nxt;
      cur_valid_r  <= cur_valid_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_node_r <= cur_node_nxt;
    next_r     <= next_nxt;
    byte_r     <= byte_nxt;
    pend_sym_r <= pend_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/htd_checker.sv -----
// port-level checks of the huffman tree-walk decoder and their binding
module htd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [htd_pkg::SYM_W-1:0] out_tdata,
  input logic                      out_tlast
);
  import htd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_LOAD) |=> in_tready)
    else $error("load request left block busy");

  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_DECODE) |=> !in_tready)
    else $error("decode request did not occupy block");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear block");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule

bind huffman_tree_decoder_core htd_checker u_htd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
